[sv/rolz_pkg.sv]
// ----------------------------------------------------------------------------
// rolz_pkg
// Shared types and constants of the ROLZ decompressor: parse modes, token
// fields, table constants and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package rolz_pkg;

    // stream positions and table entries
    localparam int          POS_W     = 17;
    localparam logic [16:0] UNSET_POS = 17'h1FFFF;

    // CRC32C, reflected
    localparam logic [31:0] CRC_POLY  = 32'h82F63B78;

    // parse modes
    localparam logic [1:0]  MODE_TOKEN   = 2'd0;
    localparam logic [1:0]  MODE_LITERAL = 2'd1;
    localparam logic [1:0]  MODE_EXTEND  = 2'd2;

    // token fields
    localparam logic [2:0]  CODE_EXT   = 3'h7;
    localparam logic [8:0]  MIN_MATCH  = 9'd2;
    localparam logic [8:0]  EXT_BASE   = 9'd9;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic decode;
        logic lit_do;
        logic bad_push;
        logic crc_match;
        logic crc_ins;
        logic tbl_rd;
        logic msel;
        logic hist_rd_copy;
        logic copy_wr;
        logic copy_push;
        logic hist_rd_win;
        logic win_load;
        logic ins_wr;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic       clr_last;
        logic [1:0] mode;
        logic       is_match;
        logic       is_ext;
        logic       mchk_bad;
        logic       crc_done;
        logic       entry_bad;
        logic       copy_flush;
        logic       len_zero;
        logic       ins_pending;
        logic       win_full;
        logic       out_free;
    } t_status;

endpackage

[sv/rolz_crc.sv]
// ----------------------------------------------------------------------------
// rolz_crc
// Iterative CRC32C of a 32-bit word (init 0, no final xor): eight bit steps
// per cycle, result ready once the step counter has run down to zero.
// ----------------------------------------------------------------------------
module rolz_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_word,
    output logic [31:0] o_crc,
    output logic        o_done
);

    logic [31:0] r_crc;
    logic [2:0]  r_cnt;

    // eight reflected shift steps
    function automatic logic [31:0] step8(input logic [31:0] c);
        logic [31:0] v;
        v = c;
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ rolz_pkg::CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_start) begin
            r_cnt <= 3'd4;
        end else if (r_cnt != 3'd0) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_crc <= i_word;
        end else if (r_cnt != 3'd0) begin
            r_crc <= step8(r_crc);
        end
    end

    assign o_crc  = r_crc;
    assign o_done = (r_cnt == 3'd0);

endmodule

[sv/rolz_ctrl.sv]
// ----------------------------------------------------------------------------
// rolz_ctrl
// Sequencer of the decompressor: table clear sweep, token decode, literal
// and match handling, byte copy and position insertion.
// ----------------------------------------------------------------------------
module rolz_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_block_start,
    input  rolz_pkg::t_status i_status,
    output rolz_pkg::t_cmd    o_cmd,
    output logic              o_in_ready
);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DECODE = 5'd2;
    localparam logic [4:0] S_LIT    = 5'd3;
    localparam logic [4:0] S_BAD    = 5'd4;
    localparam logic [4:0] S_MCHK   = 5'd5;
    localparam logic [4:0] S_MCRC   = 5'd6;
    localparam logic [4:0] S_MROW   = 5'd7;
    localparam logic [4:0] S_CRD    = 5'd8;
    localparam logic [4:0] S_CWR    = 5'd9;
    localparam logic [4:0] S_CPUSH  = 5'd10;
    localparam logic [4:0] S_INS    = 5'd11;
    localparam logic [4:0] S_IRD    = 5'd12;
    localparam logic [4:0] S_ICRC   = 5'd13;
    localparam logic [4:0] S_IROW   = 5'd14;

    logic [4:0] r_state, n_state;
    logic       r_go_decode, n_go_decode;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_go_decode <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go_decode <= n_go_decode;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_go_decode = r_go_decode;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state     = r_go_decode ? S_DECODE : S_IDLE;
                    n_go_decode = 1'b0;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_block_start) begin
                        n_state     = S_CLEAR;
                        n_go_decode = 1'b1;
                    end else begin
                        n_state = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_status.mode == rolz_pkg::MODE_LITERAL) begin
                    n_state = S_LIT;
                end else if (i_status.mode == rolz_pkg::MODE_EXTEND) begin
                    n_state = S_MCHK;
                end else if (i_status.is_match && !i_status.is_ext) begin
                    n_state = S_MCHK;
                end else begin
                    n_state = S_INS;
                end
            end
            S_LIT: begin
                if (i_status.out_free) begin
                    o_cmd.lit_do = 1'b1;
                    n_state      = S_INS;
                end
            end
            S_BAD: begin
                if (i_status.out_free) begin
                    o_cmd.bad_push = 1'b1;
                    n_state        = S_INS;
                end
            end
            S_MCHK: begin
                if (i_status.mchk_bad) begin
                    n_state = S_BAD;
                end else begin
                    o_cmd.crc_match = 1'b1;
                    n_state         = S_MCRC;
                end
            end
            S_MCRC: begin
                if (i_status.crc_done) begin
                    o_cmd.tbl_rd = 1'b1;
                    n_state      = S_MROW;
                end
            end
            S_MROW: begin
                if (i_status.entry_bad) begin
                    n_state = S_BAD;
                end else begin
                    o_cmd.msel = 1'b1;
                    n_state    = S_CRD;
                end
            end
            S_CRD: begin
                o_cmd.hist_rd_copy = 1'b1;
                n_state            = S_CWR;
            end
            S_CWR: begin
                o_cmd.copy_wr = 1'b1;
                n_state       = i_status.copy_flush ? S_CPUSH : S_CRD;
            end
            S_CPUSH: begin
                if (i_status.out_free) begin
                    o_cmd.copy_push = 1'b1;
                    n_state         = i_status.len_zero ? S_INS : S_CRD;
                end
            end
            S_INS: begin
                if (!i_status.ins_pending) begin
                    n_state = S_IDLE;
                end else if (i_status.win_full) begin
                    o_cmd.crc_ins = 1'b1;
                    n_state       = S_ICRC;
                end else begin
                    o_cmd.hist_rd_win = 1'b1;
                    n_state           = S_IRD;
                end
            end
            S_IRD: begin
                o_cmd.win_load = 1'b1;
                n_state        = S_INS;
            end
            S_ICRC: begin
                if (i_status.crc_done) begin
                    o_cmd.tbl_rd = 1'b1;
                    n_state      = S_IROW;
                end
            end
            S_IROW: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_INS;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // the accept cycle only ever happens while idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> (r_state == S_IDLE))
        else $error("accept outside idle");

    // a clear sweep started by a block start always ends in decode
    a_clear_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_status.clr_last && r_go_decode) |=> (r_state == S_DECODE))
        else $error("clear sweep did not return to decode");

    // row read only with a finished hash
    a_row_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tbl_rd |-> i_status.crc_done)
        else $error("table read before hash done");

endmodule

[sv/rolz_dp.sv]
// ----------------------------------------------------------------------------
// rolz_dp
// Datapath: history store, position table, parser registers, copy packer,
// insertion window and output register.
// ----------------------------------------------------------------------------
module rolz_dp #(
    parameter int HASH_ROW_BITS = 12,
    parameter int ROW_DEPTH     = 16,
    parameter int BLOCK_BYTES   = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_in_byte,
    input  logic              i_block_start,
    input  rolz_pkg::t_cmd    i_cmd,
    output rolz_pkg::t_status o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [63:0]       o_out_data,
    output logic [3:0]        o_out_count,
    output logic              o_run_last,
    output logic              o_bad_reference
);

    localparam int ROWS   = 1 << HASH_ROW_BITS;
    localparam int POS_W  = rolz_pkg::POS_W;
    localparam int ROW_W  = ROW_DEPTH * POS_W;
    localparam int HA_W   = $clog2(BLOCK_BYTES);
    localparam int SLOT_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam logic [POS_W:0] BLOCK_LIM = (POS_W + 1)'(BLOCK_BYTES);
    localparam logic [4:0]     DEPTH_LIM = 5'(ROW_DEPTH);

    // memories
    logic [7:0]       r_hist [BLOCK_BYTES];
    logic [ROW_W-1:0] r_tbl  [ROWS];
    logic [7:0]       r_hrd;
    logic [ROW_W-1:0] r_trd;

    // parser and position registers
    logic [POS_W-1:0] r_out_pos, r_next_ins, r_src;
    logic [1:0]       r_mode;
    logic [7:0]       r_lit_left, r_byte;
    logic [3:0]       r_pend_idx;
    logic [8:0]       r_len;
    logic [7:0]       r_l0, r_l1, r_l2;
    logic [7:0]       r_w0, r_w1, r_w2;
    logic [1:0]       r_wcnt;
    logic [63:0]      r_acc;
    logic [3:0]       r_ccnt;
    logic [HASH_ROW_BITS-1:0] r_clr_row;

    // output register
    logic        r_o_valid;
    logic [63:0] r_o_data;
    logic [3:0]  r_o_count;
    logic        r_o_last, r_o_bad;

    // hash unit
    logic        crc_start, crc_done;
    logic [31:0] crc_word, crc_val;
    logic [HASH_ROW_BITS-1:0] key;

    assign crc_start = i_cmd.crc_match | i_cmd.crc_ins;
    assign crc_word  = i_cmd.crc_ins ? {8'h00, r_w0, r_w1, r_w2}
                                     : {8'h00, r_l0, r_l1, r_l2};
    assign key       = crc_val[HASH_ROW_BITS-1:0];

    rolz_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crc_start),
        .i_word  (crc_word),
        .o_crc   (crc_val),
        .o_done  (crc_done)
    );

    // derived checks
    logic [POS_W-1:0] entry, ins_pos;
    logic [SLOT_W-1:0] slot;
    logic lit_room, push, out_free;
    logic [ROW_W-1:0] shifted;

    assign slot     = r_pend_idx[SLOT_W-1:0];
    assign entry    = r_trd[slot*POS_W +: POS_W];
    assign lit_room = {1'b0, r_out_pos} < BLOCK_LIM;
    assign ins_pos  = r_next_ins + POS_W'(3);
    assign push     = i_cmd.lit_do | i_cmd.bad_push | i_cmd.copy_push;
    assign out_free = !r_o_valid || i_out_ready;

    // row with the new position at its front
    always_comb begin
        shifted = '0;
        shifted[0 +: POS_W] = ins_pos;
        for (int j = 1; j < ROW_DEPTH; j++) begin
            shifted[j*POS_W +: POS_W] = r_trd[(j-1)*POS_W +: POS_W];
        end
    end

    // status
    always_comb begin
        o_status.clr_last    = &r_clr_row;
        o_status.mode        = r_mode;
        o_status.is_match    = r_byte[7];
        o_status.is_ext      = (r_byte[6:4] == rolz_pkg::CODE_EXT);
        o_status.mchk_bad    = (r_out_pos < POS_W'(3))
                            || ({1'b0, r_pend_idx} >= DEPTH_LIM)
                            || (({1'b0, r_out_pos} + (POS_W + 1)'(r_len)) > BLOCK_LIM);
        o_status.crc_done    = crc_done;
        o_status.entry_bad   = (entry == rolz_pkg::UNSET_POS) || (entry >= r_out_pos);
        o_status.copy_flush  = (r_ccnt == 4'd7) || (r_len == 9'd1);
        o_status.len_zero    = (r_len == 9'd0);
        o_status.ins_pending = ({1'b0, r_next_ins} + (POS_W + 1)'(3)) < {1'b0, r_out_pos};
        o_status.win_full    = (r_wcnt == 2'd3);
        o_status.out_free    = out_free;
    end

    // history store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.lit_do && lit_room) begin
            r_hist[r_out_pos[HA_W-1:0]] <= r_byte;
        end else if (i_cmd.copy_wr) begin
            r_hist[r_out_pos[HA_W-1:0]] <= r_hrd;
        end
        if (i_cmd.hist_rd_copy) begin
            r_hrd <= r_hist[r_src[HA_W-1:0]];
        end else if (i_cmd.hist_rd_win) begin
            r_hrd <= r_hist[HA_W'(r_next_ins + POS_W'(r_wcnt))];
        end
    end

    // position table: row-wide words
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_tbl[r_clr_row] <= '1;
        end else if (i_cmd.ins_wr) begin
            r_tbl[key] <= shifted;
        end
        if (i_cmd.tbl_rd) begin
            r_trd <= r_tbl[key];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_pos  <= '0;
            r_next_ins <= '0;
            r_mode     <= rolz_pkg::MODE_TOKEN;
            r_lit_left <= '0;
            r_pend_idx <= '0;
            r_wcnt     <= '0;
            r_ccnt     <= '0;
            r_len      <= '0;
            r_clr_row  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            // block start clears parser and positions
            if (i_cmd.accept && i_block_start) begin
                r_out_pos  <= '0;
                r_next_ins <= '0;
                r_mode     <= rolz_pkg::MODE_TOKEN;
                r_lit_left <= '0;
                r_pend_idx <= '0;
                r_wcnt     <= '0;
            end
            // token decode
            if (i_cmd.decode) begin
                case (r_mode)
                    rolz_pkg::MODE_LITERAL: begin
                    end
                    rolz_pkg::MODE_EXTEND: begin
                        r_mode <= rolz_pkg::MODE_TOKEN;
                        r_len  <= 9'(r_byte) + rolz_pkg::EXT_BASE;
                    end
                    default: begin
                        if (r_byte[7]) begin
                            r_pend_idx <= r_byte[3:0];
                            if (r_byte[6:4] == rolz_pkg::CODE_EXT) begin
                                r_mode <= rolz_pkg::MODE_EXTEND;
                            end else begin
                                r_len <= 9'(r_byte[6:4]) + rolz_pkg::MIN_MATCH;
                            end
                        end else begin
                            r_lit_left <= r_byte + 8'd1;
                            r_mode     <= rolz_pkg::MODE_LITERAL;
                        end
                    end
                endcase
            end
            // literal byte
            if (i_cmd.lit_do) begin
                if (lit_room) begin
                    r_out_pos <= r_out_pos + 1'b1;
                end
                r_lit_left <= r_lit_left - 8'd1;
                if (r_lit_left == 8'd1) begin
                    r_mode <= rolz_pkg::MODE_TOKEN;
                end
            end
            // copy byte
            if (i_cmd.copy_wr) begin
                r_out_pos <= r_out_pos + 1'b1;
                r_len     <= r_len - 9'd1;
                r_ccnt    <= r_ccnt + 4'd1;
            end
            if (i_cmd.copy_push) begin
                r_ccnt <= '0;
            end
            // insertion window
            if (i_cmd.win_load) begin
                r_wcnt <= r_wcnt + 2'd1;
            end
            if (i_cmd.ins_wr) begin
                r_wcnt     <= 2'd2;
                r_next_ins <= r_next_ins + 1'b1;
            end
            // output register
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_in_byte;
        end
        if (i_cmd.msel) begin
            r_src <= entry;
            r_acc <= '0;
        end
        if ((i_cmd.lit_do && lit_room) || i_cmd.copy_wr) begin
            r_l0 <= r_l1;
            r_l1 <= r_l2;
            r_l2 <= i_cmd.copy_wr ? r_hrd : r_byte;
        end
        if (i_cmd.copy_wr) begin
            r_src <= r_src + 1'b1;
            r_acc[r_ccnt[2:0]*8 +: 8] <= r_hrd;
        end
        if (i_cmd.copy_push) begin
            r_acc <= '0;
        end
        if (i_cmd.win_load) begin
            case (r_wcnt)
                2'd0:    r_w0 <= r_hrd;
                2'd1:    r_w1 <= r_hrd;
                default: r_w2 <= r_hrd;
            endcase
        end
        if (i_cmd.ins_wr) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
        end
        if (i_cmd.lit_do) begin
            r_o_data  <= lit_room ? {56'h0, r_byte} : 64'h0;
            r_o_count <= lit_room ? 4'd1 : 4'd0;
            r_o_last  <= 1'b1;
            r_o_bad   <= !lit_room;
        end else if (i_cmd.bad_push) begin
            r_o_data  <= 64'h0;
            r_o_count <= 4'd0;
            r_o_last  <= 1'b1;
            r_o_bad   <= 1'b1;
        end else if (i_cmd.copy_push) begin
            r_o_data  <= r_acc;
            r_o_count <= r_ccnt;
            r_o_last  <= (r_len == 9'd0);
            r_o_bad   <= 1'b0;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_out_data      = r_o_data;
    assign o_out_count     = r_o_count;
    assign o_run_last      = r_o_last;
    assign o_bad_reference = r_o_bad;

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_o_valid) |-> i_out_ready)
        else $error("output overwritten");

    // insertion never runs ahead of the output
    a_ins_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_ins <= r_out_pos)
        else $error("insert pointer ahead of output");

    // history never overflows
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_out_pos} <= BLOCK_LIM)
        else $error("output position beyond block");

    // copy source always lies behind the write point
    a_src_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.copy_wr |-> (r_src < r_out_pos))
        else $error("copy source not earlier");

endmodule

[sv/rolz_decompressor.sv]
// ----------------------------------------------------------------------------
// rolz_decompressor
// Reduced-offset LZ decompressor, one compressed byte per input transfer,
// decoded bytes out in transfers of up to eight.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  input    i_in_valid/o_in_ready, i_in_byte,         in
//           i_block_start
//  output   o_out_valid/i_out_ready, o_out_data,      out
//           o_out_count, o_run_last, o_bad_reference
//
//  Token byte: accept, decode, then the insertion check back to idle.
//  Literal byte: accept, decode and output push, plus insertion. Match:
//  reference checks, hash and row lookup after decode, then a history read
//  and write per copied byte and a push per packed result. Each new
//  position is then inserted by history read, hash wait, row read and write.
//  Reset and every block start clear all 2**HASH_ROW_BITS table rows.
//  A stalled output holds the sequencer at the next result to be sent.
// ----------------------------------------------------------------------------
module rolz_decompressor #(
    parameter int HASH_ROW_BITS = 12,
    parameter int ROW_DEPTH     = 16,
    parameter int BLOCK_BYTES   = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_block_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_data,
    output logic [3:0]  o_out_count,
    output logic        o_run_last,
    output logic        o_bad_reference
);

    rolz_pkg::t_cmd    cmd;
    rolz_pkg::t_status status;

    rolz_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_block_start (i_block_start),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_in_ready    (o_in_ready)
    );

    rolz_dp #(
        .HASH_ROW_BITS (HASH_ROW_BITS),
        .ROW_DEPTH     (ROW_DEPTH),
        .BLOCK_BYTES   (BLOCK_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .i_block_start   (i_block_start),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data),
        .o_out_count     (o_out_count),
        .o_run_last      (o_run_last),
        .o_bad_reference (o_bad_reference)
    );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ROLZ decompressor. Compressed bytes go in over
// the input channel; a behavioral decoder predicts every output transfer
// (data, count, last and bad-reference flags), which is checked in order.
// ----------------------------------------------------------------------------
class rolz_scoreboard;

    typedef struct {
        bit [63:0] data;
        bit [3:0]  count;
        bit        last;
        bit        bad;
    } t_chunk;

    // behavioral decoder state
    bit [7:0]  hist[65536];
    bit [16:0] rows[4096][16];
    int unsigned wr_pos, ins_pos, lits_left, slot_held;
    bit [1:0]  mode;

    t_chunk    chunk_q[$];
    int        n_errors, n_checked, n_rejected, n_copies;

    function new();
        clear_block();
    endfunction

    function void clear_block();
        foreach (rows[r, j]) rows[r][j] = rolz_pkg::UNSET_POS;
        wr_pos    = 0;
        ins_pos   = 0;
        mode      = rolz_pkg::MODE_TOKEN;
        lits_left = 0;
        slot_held = 0;
    endfunction

    // CRC32C of the three-byte context, masked to a row index
    function int unsigned row_hash(bit [7:0] a, bit [7:0] b, bit [7:0] c);
        bit [31:0] crc;
        crc = {8'h00, a, b, c};
        for (int i = 0; i < 32; i++)
            crc = crc[0] ? ((crc >> 1) ^ rolz_pkg::CRC_POLY) : (crc >> 1);
        return crc[11:0];
    endfunction

    function void push_chunk(bit [63:0] d, bit [3:0] c, bit l, bit b);
        t_chunk ch;
        ch.data = d; ch.count = c; ch.last = l; ch.bad = b;
        chunk_q.push_back(ch);
    endfunction

    function void copy_match(int unsigned slot, int unsigned len);
        int unsigned key, src, cnt;
        bit [63:0] acc;
        if (wr_pos < 3 || slot >= 16 || wr_pos + len > 65536) begin
            push_chunk(0, 0, 1, 1);
            return;
        end
        key = row_hash(hist[wr_pos-3], hist[wr_pos-2], hist[wr_pos-1]);
        src = rows[key][slot];
        if (src == rolz_pkg::UNSET_POS || src >= wr_pos) begin
            push_chunk(0, 0, 1, 1);
            return;
        end
        n_copies++;
        acc = 0;
        cnt = 0;
        // byte by byte, so an overlapping source repeats freshly written data
        for (int unsigned x = 0; x < len; x++) begin
            hist[wr_pos] = hist[src + x];
            acc |= 64'(hist[wr_pos]) << (8 * cnt);
            wr_pos++;
            cnt++;
            if (cnt == 8 || x + 1 == len) begin
                push_chunk(acc, cnt, x + 1 == len, 0);
                acc = 0;
                cnt = 0;
            end
        end
    endfunction

    // accepted input transfer: advance the decoder, queue expected results
    function void note_byte(bit [7:0] b, bit blk);
        int unsigned key;
        if (blk) clear_block();
        if (mode == rolz_pkg::MODE_LITERAL) begin
            if (wr_pos < 65536) begin
                hist[wr_pos] = b;
                wr_pos++;
                push_chunk(64'(b), 1, 1, 0);
            end else begin
                push_chunk(0, 0, 1, 1);
            end
            lits_left--;
            if (lits_left == 0) mode = rolz_pkg::MODE_TOKEN;
        end else if (mode == rolz_pkg::MODE_EXTEND) begin
            mode = rolz_pkg::MODE_TOKEN;
            copy_match(slot_held, 32'(b) + 9);
        end else if (b[7]) begin
            slot_held = b[3:0];
            if (b[6:4] == rolz_pkg::CODE_EXT) mode = rolz_pkg::MODE_EXTEND;
            else copy_match(slot_held, 32'(b[6:4]) + 2);
        end else begin
            lits_left = 32'(b) + 1;
            mode = rolz_pkg::MODE_LITERAL;
        end
        // push every new position at the front of its row
        while (ins_pos + 3 < wr_pos) begin
            key = row_hash(hist[ins_pos], hist[ins_pos+1], hist[ins_pos+2]);
            for (int j = 15; j > 0; j--) rows[key][j] = rows[key][j-1];
            rows[key][0] = ins_pos + 3;
            ins_pos++;
        end
    endfunction

    function void check_chunk(bit [63:0] d, bit [3:0] c, bit l, bit b);
        t_chunk ch;
        n_checked++;
        if (b) n_rejected++;
        if (chunk_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: unexpected result data=%h count=%0d last=%0b bad=%0b",
                         d, c, l, b);
            return;
        end
        ch = chunk_q.pop_front();
        if (ch.data !== d || ch.count !== c || ch.last !== l || ch.bad !== b) begin
            n_errors++;
            if (n_errors <= 10)
                $display({"ERROR: result %0d exp data=%h cnt=%0d last=%0b bad=%0b,",
                          " got data=%h cnt=%0d last=%0b bad=%0b"},
                         n_checked, ch.data, ch.count, ch.last, ch.bad, d, c, l, b);
        end
    endfunction

endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_block_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_out_data;
    logic [3:0]  o_out_count;
    logic        o_run_last;
    logic        o_bad_reference;

    rolz_scoreboard decoder = new();
    bit calm = 1'b0;
    int n_sent = 0;

    rolz_decompressor dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sink: random stall bursts, none in the final stretch
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 6) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // output transfers are checked at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready)
            decoder.check_chunk(o_out_data, o_out_count, o_run_last, o_bad_reference);

    // one input transfer, with an optional gap before it
    task automatic send_byte(bit [7:0] b, bit blk = 1'b0);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_block_start <= blk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decoder.note_byte(b, blk);
        n_sent++;
        @(negedge i_clk);
    endtask

    // literal run with content from a small or the full alphabet
    task automatic send_literals(int unsigned n, bit wide);
        send_byte(8'(n - 1));
        repeat (n) send_byte(wide ? 8'($urandom) : 8'($urandom_range(0, 3) + 8'h61));
    endtask

    task automatic send_match(bit [3:0] slot, bit [2:0] code, bit [7:0] ext = 8'h00);
        send_byte({1'b1, code, slot});
        if (code == rolz_pkg::CODE_EXT) send_byte(ext);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: early match, extremes, unset slot, longest copy
        send_byte(8'h00, 1'b1);
        send_byte(8'hff);
        send_match(4'h0, 3'd0);
        send_byte(8'h05);
        send_byte(8'h00); send_byte(8'h61); send_byte(8'h62);
        send_byte(8'h61); send_byte(8'h62); send_byte(8'h61);
        send_match(4'h0, 3'd6);
        send_match(4'hf, 3'd1);
        send_match(4'h0, rolz_pkg::CODE_EXT, 8'h00);
        send_match(4'h1, rolz_pkg::CODE_EXT, 8'hff);
        send_match(4'h0, rolz_pkg::CODE_EXT, 8'hff);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80);

        // random: mostly well-formed runs and matches, some noise
        while (n_sent < 280) begin
            int unsigned pick;
            if (n_sent > 240) calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_literals($urandom_range(1, 6), 1'b0);
                send_byte(8'h00, 1'b1);
            end else if (pick < 35)
                send_literals($urandom_range(1, 8), $urandom_range(0, 3) == 0);
            else if (pick < 50)
                send_match(4'($urandom_range(0, 15)), rolz_pkg::CODE_EXT,
                           $urandom_range(0, 9) == 0 ? 8'($urandom)
                                                     : 8'($urandom_range(0, 8)));
            else if (pick < 92)
                send_match($urandom_range(0, 9) < 7 ? 4'($urandom_range(0, 3))
                           : 4'($urandom_range(0, 15)), 3'($urandom_range(0, 6)));
            else if (pick < 96)
                send_literals($urandom_range(100, 128), 1'b1);
            else
                send_byte(8'($urandom), $urandom_range(0, 19) == 0);
        end
        i_in_valid <= 1'b0;

        while (decoder.chunk_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d compressed bytes; checked %0d output transfers", n_sent,
                 decoder.n_checked);
        $display("%0d matches copied, %0d rejected references, %0d mismatches",
                 decoder.n_copies, decoder.n_rejected, decoder.n_errors);
        if (decoder.n_errors == 0 && decoder.chunk_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", decoder.chunk_q.size());
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
sv/rolz_pkg.sv
sv/rolz_crc.sv
sv/rolz_ctrl.sv
sv/rolz_dp.sv
sv/rolz_decompressor.sv
tb/tb.sv
